/* hw/rtl/ocd_pkg.sv */
// ----------------------------------------------------------------------------
// ocd_pkg
// Shared types and constants for the object and command frame parser.
// ----------------------------------------------------------------------------
package ocd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned IdW    = 16;
  localparam int unsigned LenW   = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] REG_OBJECT_TYPE  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_COMMAND_TYPE = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_MAX_LENGTH   = 2'd2;

  localparam logic [ByteW-1:0] OBJECT_TYPE_RESET  = 8'd0;
  localparam logic [ByteW-1:0] COMMAND_TYPE_RESET = 8'd1;
  localparam logic [LenW-1:0]  MAX_LENGTH_RESET   = 16'hFFFF;

  localparam logic ERR_TYPE   = 1'b0;
  localparam logic ERR_LENGTH = 1'b1;

  typedef enum logic [1:0] {
    KIND_COMMAND = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_EMPTY   = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    PH_TYPE    = 4'd0,
    PH_OBJ_ID1 = 4'd1,
    PH_OBJ_ID2 = 4'd2,
    PH_LEN1    = 4'd3,
    PH_LEN2    = 4'd4,
    PH_PAYLOAD = 4'd5,
    PH_CMD_ID1 = 4'd6,
    PH_CMD_ID2 = 4'd7,
    PH_ERROR   = 4'd8
  } phase_t;

  typedef struct packed {
    logic [ByteW-1:0] object_type_code;
    logic [ByteW-1:0] command_type_code;
    logic [LenW-1:0]  max_payload_length;
  } cfg_t;

  typedef struct packed {
    kind_t             kind;
    logic [IdW-1:0]    id;
    logic [ByteW-1:0]  data;
    logic [LenW-1:0]   index;
    logic              last;
    logic              err;
  } result_t;

endpackage

/* hw/rtl/ocd_cfg_regs.sv */
// ----------------------------------------------------------------------------
// ocd_cfg_regs
// Configuration registers written through the configuration channel.
// ----------------------------------------------------------------------------
module ocd_cfg_regs
  import ocd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output cfg_t                cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.object_type_code   <= OBJECT_TYPE_RESET;
      cfg.command_type_code  <= COMMAND_TYPE_RESET;
      cfg.max_payload_length <= MAX_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_OBJECT_TYPE:  cfg.object_type_code   <= cfg_data[ByteW-1:0];
        REG_COMMAND_TYPE: cfg.command_type_code  <= cfg_data[ByteW-1:0];
        REG_MAX_LENGTH:   cfg.max_payload_length <= cfg_data[LenW-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* hw/rtl/ocd_parser.sv */
// ----------------------------------------------------------------------------
// ocd_parser
// Frame state machine that consumes one byte per accepted transaction.
// ----------------------------------------------------------------------------
module ocd_parser
  import ocd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [ByteW-1:0] data_byte,
  input  cfg_t             cfg,
  output logic             res_valid,
  output result_t          res
);

  phase_t          phase, phase_next;
  logic [IdW-1:0]  frame_id, frame_id_next;
  logic [LenW-1:0] remaining, remaining_next;
  logic [LenW-1:0] position, position_next;
  logic [LenW-1:0] length_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_TYPE;
      frame_id  <= '0;
      remaining <= '0;
      position  <= '0;
    end else if (accept) begin
      phase     <= phase_next;
      frame_id  <= frame_id_next;
      remaining <= remaining_next;
      position  <= position_next;
    end
  end

  assign length_full = {data_byte, remaining[ByteW-1:0]};

  always_comb begin
    phase_next     = phase;
    frame_id_next  = frame_id;
    remaining_next = remaining;
    position_next  = position;
    res_valid      = 1'b0;
    res            = '0;
    res.id         = frame_id;
    case (phase)
      PH_TYPE: begin
        if (data_byte == cfg.object_type_code) begin
          phase_next = PH_OBJ_ID1;
        end else if (data_byte == cfg.command_type_code) begin
          phase_next = PH_CMD_ID1;
        end else begin
          phase_next = PH_ERROR;
          res_valid  = 1'b1;
          res.kind   = KIND_ERROR;
          res.err    = ERR_TYPE;
        end
      end
      PH_OBJ_ID1, PH_CMD_ID1: begin
        frame_id_next = {{(IdW-ByteW){1'b0}}, data_byte};
        phase_next    = (phase == PH_OBJ_ID1) ? PH_OBJ_ID2 : PH_CMD_ID2;
      end
      PH_OBJ_ID2: begin
        frame_id_next = {data_byte, frame_id[ByteW-1:0]};
        phase_next    = PH_LEN1;
      end
      PH_CMD_ID2: begin
        res_valid     = 1'b1;
        res.kind      = KIND_COMMAND;
        res.id        = {data_byte, frame_id[ByteW-1:0]};
        phase_next    = PH_TYPE;
        frame_id_next = '0;
      end
      PH_LEN1: begin
        remaining_next = {{(LenW-ByteW){1'b0}}, data_byte};
        phase_next     = PH_LEN2;
      end
      PH_LEN2: begin
        remaining_next = length_full;
        if (length_full > cfg.max_payload_length) begin
          phase_next = PH_ERROR;
          res_valid  = 1'b1;
          res.kind   = KIND_ERROR;
          res.err    = ERR_LENGTH;
        end else if (length_full == '0) begin
          res_valid     = 1'b1;
          res.kind      = KIND_EMPTY;
          res.last      = 1'b1;
          phase_next    = PH_TYPE;
          frame_id_next = '0;
        end else begin
          phase_next    = PH_PAYLOAD;
          position_next = '0;
        end
      end
      PH_PAYLOAD: begin
        res_valid      = 1'b1;
        res.kind       = KIND_PAYLOAD;
        res.data       = data_byte;
        res.index      = position;
        res.last       = (remaining <= LenW'(1));
        position_next  = position + LenW'(1);
        remaining_next = remaining - LenW'(1);
        if (res.last) begin
          phase_next     = PH_TYPE;
          frame_id_next  = '0;
          remaining_next = '0;
          position_next  = '0;
        end
      end
      default: ;
    endcase
  end

endmodule

/* hw/rtl/ocd_out_buf.sv */
// ----------------------------------------------------------------------------
// ocd_out_buf
// Result register with a skid stage so input flow continues under stall.
// ----------------------------------------------------------------------------
module ocd_out_buf
  import ocd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    res_valid,
  input  result_t res,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_res
);

  logic    skid_valid;
  result_t skid_res;
  logic    take;

  assign take = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (res_valid) begin
      if (out_valid && !take) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        out_res <= skid_res;
      end
    end else if (res_valid) begin
      if (out_valid && !take) begin
        skid_res <= res;
      end else begin
        out_res <= res;
      end
    end
  end

endmodule

/* hw/rtl/object_command_deframer.sv */
// ----------------------------------------------------------------------------
// object_command_deframer
// Byte-serial parser for object and command frames with payload streaming.
// ----------------------------------------------------------------------------
// Each result is registered into the output stage when its byte is accepted.
// Throughput: one byte per cycle while in_stall is low.
// A two-entry output stage (result register plus skid) raises in_stall only
// when both entries hold results not yet taken.
// Reset clears the parser to wait for a type byte, empties the output stage
// and restores the configuration registers; the error state is left by reset.
module object_command_deframer
  import ocd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ByteW-1:0]    data_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          result_kind,
  output logic [IdW-1:0]      message_id,
  output logic [ByteW-1:0]    payload_byte,
  output logic [LenW-1:0]     payload_index,
  output logic                last_of_object,
  output logic                error_code
);

  cfg_t    cfg;
  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_res;
  logic    full;

  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  ocd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ocd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  ocd_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (accept && res_valid),
    .res       (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign result_kind    = out_res.kind;
  assign message_id     = out_res.id;
  assign payload_byte   = out_res.data;
  assign payload_index  = out_res.index;
  assign last_of_object = out_res.last;
  assign error_code     = out_res.err;

endmodule

/* hw/rtl/ocd_checker.sv */
// ----------------------------------------------------------------------------
// ocd_checker
// Port-level checks for the frame parser, attached to the top level by bind.
// ----------------------------------------------------------------------------
module ocd_checker
  import ocd_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_stall,
  input logic [1:0]       result_kind,
  input logic [IdW-1:0]   message_id,
  input logic [ByteW-1:0] payload_byte,
  input logic [LenW-1:0]  payload_index,
  input logic             last_of_object,
  input logic             error_code
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Output valid after reset.");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("Stalled output transaction dropped.");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable({result_kind, message_id, payload_byte,
                                        payload_index, last_of_object, error_code}))
    else $error("Stalled output transaction changed.");

  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_EMPTY |->
      last_of_object && payload_index == '0 && payload_byte == '0 && !error_code)
    else $error("Empty object transaction has inconsistent fields.");

  a_error_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_ERROR |->
      !last_of_object && payload_index == '0 && payload_byte == '0
      && (error_code == ERR_LENGTH || message_id == '0))
    else $error("Error transaction has inconsistent fields.");

endmodule

bind object_command_deframer ocd_checker u_ocd_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .result_kind    (result_kind),
  .message_id     (message_id),
  .payload_byte   (payload_byte),
  .payload_index  (payload_index),
  .last_of_object (last_of_object),
  .error_code     (error_code)
);

/* test/object_command_deframer_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// object_command_deframer_tb
// Self-checking bench for the object and command frame parser. A short table
// of hand-written frames runs first. Random well-formed commands and objects
// follow under several register settings, with random gaps on the byte input
// and random stalls on the result output, save in one quiet setting. A single
// error frame closes the run, as the error state is left only by reset. Every
// result is checked field by field against a typed row or a behavioral model.
// ----------------------------------------------------------------------------
module object_command_deframer_tb;
  import ocd_pkg::*;

  localparam int unsigned IdleLimit = 1000;
  localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    ROW_QUIET,
    ROW_TYPED,
    ROW_PREDICT
  } row_mode_t;

  typedef struct {
    logic [ByteW-1:0] data;
    row_mode_t        mode;
    result_t          want;
  } stim_row_t;

  logic                clk;
  logic                rst;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic                in_valid;
  logic                in_stall;
  logic [ByteW-1:0]    data_byte;
  logic                out_valid;
  logic                out_stall;
  logic [1:0]          result_kind;
  logic [IdW-1:0]      message_id;
  logic [ByteW-1:0]    payload_byte;
  logic [LenW-1:0]     payload_index;
  logic                last_of_object;
  logic                error_code;

  object_command_deframer uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .result_kind    (result_kind),
    .message_id     (message_id),
    .payload_byte   (payload_byte),
    .payload_index  (payload_index),
    .last_of_object (last_of_object),
    .error_code     (error_code)
  );

  cfg_t          parser_cfg;
  phase_t        parse_state;
  logic [IdW-1:0]  frame_ident;
  logic [LenW-1:0] bytes_left;
  logic [LenW-1:0] next_index;
  logic            error_seen;

  result_t   pending_results[$];
  stim_row_t directed_rows[22];
  int        fail_count;
  int        bytes_sent;
  int        idle_cycles;
  bit        quiet;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic result_t res(input kind_t kind, input logic [IdW-1:0] id,
                                  input logic [ByteW-1:0] data,
                                  input logic [LenW-1:0] index,
                                  input logic last, input logic err);
    result_t r;
    r.kind  = kind;
    r.id    = id;
    r.data  = data;
    r.index = index;
    r.last  = last;
    r.err   = err;
    return r;
  endfunction

  function automatic stim_row_t row(input logic [ByteW-1:0] data, input row_mode_t mode,
                                    input result_t want);
    stim_row_t s;
    s.data = data;
    s.mode = mode;
    s.want = want;
    return s;
  endfunction

  function automatic void end_frame();
    parse_state = PH_TYPE;
    frame_ident = '0;
    bytes_left  = '0;
    next_index  = '0;
  endfunction

  function automatic bit deframe_byte(input logic [ByteW-1:0] b, output result_t r);
    logic last;
    r = res(KIND_COMMAND, '0, '0, '0, 1'b0, 1'b0);
    case (parse_state)
      PH_TYPE: begin
        if (b == parser_cfg.object_type_code) begin
          parse_state = PH_OBJ_ID1;
          return 1'b0;
        end
        if (b == parser_cfg.command_type_code) begin
          parse_state = PH_CMD_ID1;
          return 1'b0;
        end
        parse_state = PH_ERROR;
        error_seen  = ERR_TYPE;
        r = res(KIND_ERROR, frame_ident, '0, '0, 1'b0, ERR_TYPE);
        return 1'b1;
      end
      PH_OBJ_ID1, PH_CMD_ID1: begin
        frame_ident = {8'h00, b};
        parse_state = (parse_state == PH_OBJ_ID1) ? PH_OBJ_ID2 : PH_CMD_ID2;
        return 1'b0;
      end
      PH_OBJ_ID2: begin
        frame_ident[15:8] = b;
        parse_state = PH_LEN1;
        return 1'b0;
      end
      PH_CMD_ID2: begin
        r = res(KIND_COMMAND, {b, frame_ident[7:0]}, '0, '0, 1'b0, 1'b0);
        end_frame();
        return 1'b1;
      end
      PH_LEN1: begin
        bytes_left  = {8'h00, b};
        parse_state = PH_LEN2;
        return 1'b0;
      end
      PH_LEN2: begin
        bytes_left[15:8] = b;
        if (bytes_left > parser_cfg.max_payload_length) begin
          parse_state = PH_ERROR;
          error_seen  = ERR_LENGTH;
          r = res(KIND_ERROR, frame_ident, '0, '0, 1'b0, ERR_LENGTH);
          return 1'b1;
        end
        if (bytes_left == 0) begin
          r = res(KIND_EMPTY, frame_ident, '0, '0, 1'b1, 1'b0);
          end_frame();
          return 1'b1;
        end
        parse_state = PH_PAYLOAD;
        next_index  = '0;
        return 1'b0;
      end
      PH_PAYLOAD: begin
        last = (bytes_left <= 1);
        r = res(KIND_PAYLOAD, frame_ident, b, next_index, last, 1'b0);
        next_index = next_index + 1'b1;
        bytes_left = bytes_left - 1'b1;
        if (last) end_frame();
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic send_byte(input logic [ByteW-1:0] b, input row_mode_t mode,
                           input result_t want);
    result_t r;
    bit      produced;
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    produced = deframe_byte(b, r);
    bytes_sent++;
    if (mode == ROW_TYPED) pending_results.push_back(want);
    else if (mode == ROW_PREDICT && produced) pending_results.push_back(r);
  endtask

  task automatic send_random(input logic [ByteW-1:0] b);
    send_byte(b, ROW_PREDICT, res(KIND_COMMAND, '0, '0, '0, 1'b0, 1'b0));
  endtask

  task automatic stop_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_OBJECT_TYPE:  parser_cfg.object_type_code   = value[ByteW-1:0];
      REG_COMMAND_TYPE: parser_cfg.command_type_code  = value[ByteW-1:0];
      REG_MAX_LENGTH:   parser_cfg.max_payload_length = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_codes(input logic [ByteW-1:0] obj, input logic [ByteW-1:0] cmd,
                           input logic [LenW-1:0] max_len);
    write_reg(REG_OBJECT_TYPE, {8'($urandom_range(255)), obj});
    write_reg(REG_COMMAND_TYPE, {8'($urandom_range(255)), cmd});
    write_reg(REG_MAX_LENGTH, max_len);
  endtask

  task automatic drain_results();
    stop_input();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_command();
    send_random(parser_cfg.command_type_code);
    send_random(8'($urandom_range(255)));
    send_random(8'($urandom_range(255)));
  endtask

  task automatic send_object(input int len);
    send_random(parser_cfg.object_type_code);
    send_random(8'($urandom_range(255)));
    send_random(8'($urandom_range(255)));
    send_random(len[7:0]);
    send_random(len[15:8]);
    for (int i = 0; i < len; i++) send_random(8'($urandom_range(255)));
  endtask

  task automatic run_frames(input int count, input int len_cap);
    int target;
    int len;
    target = bytes_sent + count;
    while (bytes_sent < target) begin
      if ($urandom_range(99) < 40 &&
          parser_cfg.object_type_code != parser_cfg.command_type_code) begin
        send_command();
      end else begin
        len = ($urandom_range(9) == 0) ? 0 : $urandom_range(len_cap, 1);
        if (len > parser_cfg.max_payload_length) len = parser_cfg.max_payload_length;
        send_object(len);
      end
    end
  endtask

  task automatic report_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transaction, expected none actual kind %0d id %0h",
                 $time, result_kind, message_id);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        report_field("result_kind", int'(want.kind), int'(result_kind));
        report_field("message_id", int'(want.id), int'(message_id));
        report_field("payload_byte", int'(want.data), int'(payload_byte));
        report_field("payload_index", int'(want.index), int'(payload_index));
        report_field("last_of_object", int'(want.last), int'(last_of_object));
        report_field("error_code", int'(want.err), int'(error_code));
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 19);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [ByteW-1:0] bad;
    int               len;
    rst         = 1'b1;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    data_byte   = '0;
    out_stall   = 1'b0;
    quiet       = 1'b0;
    fail_count  = 0;
    bytes_sent  = 0;
    idle_cycles = 0;
    parser_cfg.object_type_code   = OBJECT_TYPE_RESET;
    parser_cfg.command_type_code  = COMMAND_TYPE_RESET;
    parser_cfg.max_payload_length = MAX_LENGTH_RESET;
    error_seen = 1'b0;
    end_frame();

    directed_rows = '{
      row(8'h01, ROW_QUIET, '0),
      row(8'h00, ROW_QUIET, '0),
      row(8'h00, ROW_TYPED, res(KIND_COMMAND, 16'h0000, 8'h00, 16'h0000, 1'b0, 1'b0)),
      row(8'h01, ROW_QUIET, '0),
      row(8'hFF, ROW_QUIET, '0),
      row(8'hFF, ROW_TYPED, res(KIND_COMMAND, 16'hFFFF, 8'h00, 16'h0000, 1'b0, 1'b0)),
      row(8'h01, ROW_QUIET, '0),
      row(8'hA5, ROW_QUIET, '0),
      row(8'h5A, ROW_PREDICT, '0),
      row(8'h00, ROW_QUIET, '0),
      row(8'h34, ROW_QUIET, '0),
      row(8'h12, ROW_QUIET, '0),
      row(8'h00, ROW_QUIET, '0),
      row(8'h00, ROW_TYPED, res(KIND_EMPTY, 16'h1234, 8'h00, 16'h0000, 1'b1, 1'b0)),
      row(8'h00, ROW_QUIET, '0),
      row(8'hFF, ROW_QUIET, '0),
      row(8'hFF, ROW_QUIET, '0),
      row(8'h03, ROW_QUIET, '0),
      row(8'h00, ROW_QUIET, '0),
      row(8'hFF, ROW_TYPED, res(KIND_PAYLOAD, 16'hFFFF, 8'hFF, 16'h0000, 1'b0, 1'b0)),
      row(8'h00, ROW_TYPED, res(KIND_PAYLOAD, 16'hFFFF, 8'h00, 16'h0001, 1'b0, 1'b0)),
      row(8'h5A, ROW_PREDICT, '0)
    };

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].data, directed_rows[i].mode, directed_rows[i].want);
    end
    drain_results();

    set_codes(8'hFF, 8'h00, 16'hFFFF);
    write_reg(REG_UNUSED, 16'($urandom_range(65535)));
    run_frames(150, 12);
    send_object(300);
    drain_results();

    set_codes(8'($urandom_range(127)), 8'($urandom_range(255, 128)), 16'h0000);
    run_frames(120, 8);
    drain_results();

    bad = 8'($urandom_range(255));
    set_codes(bad, bad, 16'd5);
    run_frames(150, 8);
    drain_results();

    quiet = 1'b1;
    set_codes(8'($urandom_range(255, 128)), 8'($urandom_range(127)), 16'd20);
    run_frames(250, 20);
    drain_results();
    quiet = 1'b0;

    set_codes(8'($urandom_range(127)), 8'($urandom_range(255, 128)),
              16'($urandom_range(64, 1)));
    run_frames(250, 16);
    drain_results();

    if ($urandom_range(1) == 0) begin
      bad = 8'($urandom_range(255));
      while (bad == parser_cfg.object_type_code || bad == parser_cfg.command_type_code)
        bad = 8'($urandom_range(255));
      send_random(bad);
    end else begin
      len = int'(parser_cfg.max_payload_length) + $urandom_range(3, 1);
      send_random(parser_cfg.object_type_code);
      send_random(8'($urandom_range(255)));
      send_random(8'($urandom_range(255)));
      send_random(len[7:0]);
      send_random(len[15:8]);
    end
    repeat (12) send_random(8'($urandom_range(255)));
    drain_results();
    repeat (10) @(posedge clk);

    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* object_command_deframer.f */
hw/rtl/ocd_pkg.sv
hw/rtl/ocd_cfg_regs.sv
hw/rtl/ocd_parser.sv
hw/rtl/ocd_out_buf.sv
hw/rtl/object_command_deframer.sv
hw/rtl/ocd_checker.sv
test/object_command_deframer_tb.sv
